// ===== rtl/core/ipl_pkg.sv =====
package ipl_pkg;

  localparam int SINE_DEPTH_DEF = 1024;

  localparam int POS_W   = 32;
  localparam int STEP_W  = 31;
  localparam int GGAIN_W = 31;
  localparam int OFFS_W  = 26;
  localparam int DIV_W   = 16;
  localparam int CFG_W   = 31;
  localparam int GAIN_W  = 23;
  localparam int ERR_W   = 33;
  localparam int IQ_W    = 24;
  localparam int ENTRY_W = 16;
  localparam int GRAV_W  = 25;

  localparam int SNAP_WINDOW = 3277;
  localparam int BLEND_ALPHA = 6554;

  // full turn in Q16.16 degrees is TURN_DIV << TURN_SHIFT
  localparam int TURN_DIV   = 45;
  localparam int TURN_SHIFT = 19;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_SET_MODE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_SOFT   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_HARD   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_RAMP_STEP      = 2'd0,
    CFG_GRAVITY_GAIN   = 2'd1,
    CFG_GRAVITY_OFFSET = 2'd2,
    CFG_LOOP_DIVIDER   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] k;
    logic [GAIN_W-1:0] b;
    logic [GAIN_W-1:0] lim;
    logic [GAIN_W-1:0] db;
  } gains_t;

  function automatic gains_t gain_set(input mode_t m);
    gains_t g;
    unique case (m)
      MODE_SOFT: begin
        g.k = 23'd838861;  g.b = 23'd50332;  g.lim = 23'd131072; g.db = 23'd9830;
      end
      MODE_HARD: begin
        g.k = 23'd5033165; g.b = 23'd251658; g.lim = 23'd262144; g.db = 23'd5243;
      end
      default: begin
        g.k = 23'd2013266; g.b = 23'd100663; g.lim = 23'd196608; g.db = 23'd6554;
      end
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/ipl_gravity.sv =====
module ipl_gravity #(
  parameter int SINE_TABLE_DEPTH = ipl_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic [5:1]                          stage_load,
  input  logic signed [ipl_pkg::POS_W-1:0]    meas,
  input  logic signed [ipl_pkg::OFFS_W-1:0]   offset,
  input  logic [ipl_pkg::GGAIN_W-1:0]         gain,
  output logic signed [ipl_pkg::GRAV_W-1:0]   grav
);

  localparam int X_W      = ipl_pkg::POS_W + 1;
  localparam int Z_W      = X_W - ipl_pkg::TURN_SHIFT;
  localparam int W_W      = Z_W;
  localparam int W_BIAS   = ipl_pkg::TURN_DIV * 128;
  localparam int W_SHIFT  = W_W + 6;
  localparam int W_RECIP  = ((1 << W_SHIFT) + ipl_pkg::TURN_DIV - 1) / ipl_pkg::TURN_DIV;
  localparam int WP_W     = W_W + W_SHIFT - 5;
  localparam int R_W      = 6;
  localparam int ANG_W    = R_W + ipl_pkg::TURN_SHIFT;
  localparam int D_W      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int AD_W     = ANG_W + D_W;
  localparam int U_W      = $clog2(ipl_pkg::TURN_DIV * SINE_TABLE_DEPTH);
  localparam int I_SHIFT  = U_W + 6;
  localparam int I_RECIP  = ((1 << I_SHIFT) + ipl_pkg::TURN_DIV - 1) / ipl_pkg::TURN_DIV;
  localparam int IP_W     = U_W + I_SHIFT - 5;
  localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
  localparam int GP_W     = ipl_pkg::GGAIN_W + 1 + ipl_pkg::ENTRY_W;
  localparam int GRAV_SH  = 23;

  function automatic logic signed [ipl_pkg::ENTRY_W-1:0] sine_entry(input int unsigned idx);
    logic [63:0] p;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    p = (64'(idx) << 32) / SINE_TABLE_DEPTH;
    quad = (p >> 30) & 64'd3;
    r = p & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'h4000_0000 - r;
    x = (r * ipl_pkg::HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum = sum + term;
    sum = (sum + 64'd16384) >> 15;
    if (sum > 64'd32767) sum = 64'd32767;
    return (quad >= 64'd2) ? -$signed(sum[ipl_pkg::ENTRY_W-1:0])
                           : $signed(sum[ipl_pkg::ENTRY_W-1:0]);
  endfunction

  logic signed [ipl_pkg::ENTRY_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic signed [ipl_pkg::ENTRY_W-1:0] ENTRY = sine_entry(i);
    assign sine_rom[i] = ENTRY;
  end

  logic signed [X_W-1:0]   x_diff;
  logic signed [Z_W-1:0]   z_turn;
  logic signed [W_W:0]     w_biased;
  logic [W_W-1:0]          w_val;
  logic [WP_W-1:0]         w_prod;
  logic [W_W-1:0]          w_quo;
  logic [W_W-1:0]          w_rem;
  logic [AD_W-1:0]         ang_scaled;
  logic [IP_W-1:0]         idx_prod;
  logic signed [GP_W-1:0]  grav_biased;

  logic [ANG_W-1:0]                    s1_ang;
  logic [U_W-1:0]                      s2_u;
  logic [IDX_W-1:0]                    s3_idx;
  logic signed [ipl_pkg::ENTRY_W-1:0]  s4_sine;
  logic signed [GP_W-1:0]              s5_prod;

  // wrap into one turn: split off the low bits, then take the rest modulo 45
  always_comb begin
    x_diff   = X_W'(meas) - X_W'(offset);
    z_turn   = x_diff[X_W-1:ipl_pkg::TURN_SHIFT];
    w_biased = (W_W+1)'(z_turn) + (W_W+1)'(W_BIAS);
    w_val    = w_biased[W_W-1:0];
    w_prod   = WP_W'(w_val) * WP_W'(W_RECIP);
    w_quo    = W_W'(w_prod >> W_SHIFT);
    w_rem    = w_val - W_W'(w_quo * W_W'(ipl_pkg::TURN_DIV));
  end

  assign ang_scaled = AD_W'(s1_ang) * AD_W'(SINE_TABLE_DEPTH);
  assign idx_prod   = IP_W'(s2_u) * IP_W'(I_RECIP);

  always_ff @(posedge clk) begin
    if (stage_load[1]) s1_ang <= {w_rem[R_W-1:0], x_diff[ipl_pkg::TURN_SHIFT-1:0]};
    if (stage_load[2]) s2_u <= U_W'(ang_scaled >> ipl_pkg::TURN_SHIFT);
    if (stage_load[3]) s3_idx <= IDX_W'(idx_prod >> I_SHIFT);
    if (stage_load[4]) s4_sine <= sine_rom[s3_idx];
    if (stage_load[5]) s5_prod <= GP_W'($signed({1'b0, gain})) * GP_W'(s4_sine);
  end

  assign grav_biased = s5_prod + GP_W'(s5_prod[GP_W-1] ? (1 << (GRAV_SH - 1)) - 1
                                                       : (1 << (GRAV_SH - 1)));
  assign grav = grav_biased[GRAV_SH +: ipl_pkg::GRAV_W];

endmodule

// ===== rtl/core/impedance_position_loop_core.sv =====
// Outer position loop of a joint drive. Each input beat is either a control tick (tuser 0)
// carrying target position, measured position and measured speed, or a set-mode beat
// (tuser 1) that loads or blends the soft/normal/hard impedance gains. Every loop_divider-th
// tick runs an update: the commanded position slews toward the target by at most ramp_step
// (snapping to the target inside SNAP_WINDOW), the deadbanded error drives stiffness*error
// - damping*speed clamped to the current limit, and a gravity term
// gravity_gain*sin(measured - gravity_offset) from a sine ROM is added; other beats return
// the held current command. Every input beat yields one output beat. The block takes one
// beat per clock while the output is not stalled; the gravity path (angle wrap, table
// index, registered ROM read, gain multiply) runs alongside the ramp and impedance stages.
module impedance_position_loop_core #(
  parameter int SINE_TABLE_DEPTH = ipl_pkg::SINE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [103:0]  s_tdata,   // impedance_mode, setpoint, measured_position,
                                   // measured_speed, zero pad
  input  logic [0:0]    s_tuser,   // opcode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,   // iq_command, position_command
  output logic [0:0]    m_tuser,   // updated
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [ipl_pkg::CFG_W-1:0] cfg_data
);

  localparam int LAST   = 6;
  localparam int POS_W  = ipl_pkg::POS_W;
  localparam int ERR_W  = ipl_pkg::ERR_W;
  localparam int GAIN_W = ipl_pkg::GAIN_W;
  localparam int IQ_W   = ipl_pkg::IQ_W;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - 24;
  localparam int TOT_W  = ipl_pkg::GRAV_W + 1;
  localparam int BL_W   = GAIN_W + 15;

  localparam ipl_pkg::gains_t SOFT_SET = ipl_pkg::gain_set(ipl_pkg::MODE_SOFT);
  localparam ipl_pkg::gains_t HARD_SET = ipl_pkg::gain_set(ipl_pkg::MODE_HARD);

  function automatic logic [GAIN_W-1:0] blend(input logic [GAIN_W-1:0] cur,
                                               input logic [GAIN_W-1:0] goal);
    logic signed [GAIN_W:0] diff;
    logic signed [BL_W-1:0] scaled;
    logic signed [BL_W-1:0] biased;
    diff   = $signed({1'b0, goal}) - $signed({1'b0, cur});
    scaled = BL_W'(diff) * BL_W'(ipl_pkg::BLEND_ALPHA);
    biased = scaled + BL_W'(scaled[BL_W-1] ? 32767 : 32768);
    return cur + GAIN_W'(biased >>> 16);
  endfunction

  // configuration
  logic [ipl_pkg::STEP_W-1:0]         ramp_step;
  logic [ipl_pkg::GGAIN_W-1:0]        gravity_gain;
  logic signed [ipl_pkg::OFFS_W-1:0]  gravity_offset;
  logic [ipl_pkg::DIV_W-1:0]          loop_divider;

  // loop state
  logic signed [POS_W-1:0]    ramp_position;
  logic                       ramp_started;
  logic [ipl_pkg::DIV_W-1:0]  tick_counter;
  ipl_pkg::gains_t            gains;
  logic                       gains_loaded;

  // pipeline control
  logic [LAST:0] vld;
  logic [LAST:0] take;
  logic [LAST:0] load;

  // input register
  ipl_pkg::opcode_t         s0_op;
  logic [1:0]               s0_mode;
  logic signed [POS_W-1:0]  s0_target;
  logic signed [POS_W-1:0]  s0_meas;
  logic signed [POS_W-1:0]  s0_speed;

  // update stage
  logic                       is_tick;
  logic [ipl_pkg::DIV_W-1:0]  tick_inc;
  logic                       do_update;
  logic signed [POS_W-1:0]    ramp_base;
  logic signed [ERR_W-1:0]    ramp_err;
  logic signed [ERR_W-1:0]    step_pos;
  logic signed [ERR_W-1:0]    ramp_delta;
  logic signed [ERR_W-1:0]    ramp_sum;
  logic signed [POS_W-1:0]    ramp_next;
  logic signed [ERR_W-1:0]    err_raw;
  logic signed [ERR_W-1:0]    db_ext;
  logic signed [ERR_W-1:0]    err_db;
  ipl_pkg::gains_t            goal;
  ipl_pkg::gains_t            gains_next;

  logic                       s1_upd;
  logic signed [ERR_W-1:0]    s1_err;
  logic signed [POS_W-1:0]    s1_speed;
  logic [GAIN_W-1:0]          s1_k;
  logic [GAIN_W-1:0]          s1_b;
  logic [GAIN_W-1:0]          s1_lim;
  logic signed [POS_W-1:0]    s1_pos;

  logic                       s2_upd;
  logic signed [PROD_W-1:0]   s2_pk;
  logic signed [PROD_W-1:0]   s2_pb;
  logic [GAIN_W-1:0]          s2_lim;
  logic signed [POS_W-1:0]    s2_pos;

  logic signed [SUM_W-1:0]    imp_sum;
  logic signed [SUM_W-1:0]    imp_biased;
  logic signed [RND_W-1:0]    imp_round;
  logic signed [RND_W-1:0]    lim_ext;
  logic signed [RND_W-1:0]    imp_clamp;

  logic                       s3_upd;
  logic signed [IQ_W-1:0]     s3_iq;
  logic signed [POS_W-1:0]    s3_pos;
  logic                       s4_upd;
  logic signed [IQ_W-1:0]     s4_iq;
  logic signed [POS_W-1:0]    s4_pos;
  logic                       s5_upd;
  logic signed [IQ_W-1:0]     s5_iq;
  logic signed [POS_W-1:0]    s5_pos;

  logic signed [ipl_pkg::GRAV_W-1:0] grav;
  logic signed [TOT_W-1:0]    total;

  // output register; out_iq doubles as the held current command
  logic signed [POS_W-1:0]    out_iq;
  logic signed [POS_W-1:0]    out_pos;
  logic                       out_upd;

  always_comb begin
    take[LAST] = m_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      take[i] = !vld[i+1] || take[i+1];
    end
    load[0] = s_tvalid && (!vld[0] || take[0]);
    for (int i = 1; i <= LAST; i++) begin
      load[i] = vld[i-1] && take[i-1];
    end
  end

  assign s_tready = !vld[0] || take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= load | (vld & ~take);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step      <= ipl_pkg::STEP_W'(65536);
      gravity_gain   <= ipl_pkg::GGAIN_W'(6375342);
      gravity_offset <= '0;
      loop_divider   <= ipl_pkg::DIV_W'(10);
    end else if (cfg_write) begin
      unique case (ipl_pkg::cfg_reg_t'(cfg_index))
        ipl_pkg::CFG_RAMP_STEP:      ramp_step <= cfg_data;
        ipl_pkg::CFG_GRAVITY_GAIN:   gravity_gain <= cfg_data;
        ipl_pkg::CFG_GRAVITY_OFFSET: gravity_offset <= $signed(cfg_data[ipl_pkg::OFFS_W-1:0]);
        ipl_pkg::CFG_LOOP_DIVIDER:   loop_divider <= cfg_data[ipl_pkg::DIV_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s0_op     <= ipl_pkg::opcode_t'(s_tuser[0]);
      s0_mode   <= s_tdata[1:0];
      s0_target <= $signed(s_tdata[33:2]);
      s0_meas   <= $signed(s_tdata[65:34]);
      s0_speed  <= $signed(s_tdata[97:66]);
    end
  end

  always_comb begin
    is_tick   = (s0_op == ipl_pkg::OP_TICK);
    tick_inc  = tick_counter + ipl_pkg::DIV_W'(1);
    do_update = is_tick && (tick_inc >= loop_divider);
    ramp_base = ramp_started ? ramp_position : s0_meas;
    ramp_err  = ERR_W'(s0_target) - ERR_W'(ramp_base);
    step_pos  = $signed({2'b00, ramp_step});
    if (ramp_err > step_pos) begin
      ramp_delta = step_pos;
    end else if (ramp_err < -step_pos) begin
      ramp_delta = -step_pos;
    end else begin
      ramp_delta = ramp_err;
    end
    ramp_sum = ERR_W'(ramp_base) + ramp_delta;
    if (ramp_err <= ERR_W'(ipl_pkg::SNAP_WINDOW) && ramp_err >= -ERR_W'(ipl_pkg::SNAP_WINDOW)) begin
      ramp_next = s0_target;
    end else begin
      ramp_next = ramp_sum[POS_W-1:0];
    end
    err_raw = ERR_W'(ramp_next) - ERR_W'(s0_meas);
    db_ext  = $signed({(ERR_W - GAIN_W)'(0), gains.db});
    err_db  = (err_raw < db_ext && err_raw > -db_ext) ? '0 : err_raw;
    goal    = ipl_pkg::gain_set(ipl_pkg::mode_t'(s0_mode));
    if (gains_loaded) begin
      gains_next.k   = blend(gains.k, goal.k);
      gains_next.b   = blend(gains.b, goal.b);
      gains_next.lim = blend(gains.lim, goal.lim);
      gains_next.db  = blend(gains.db, goal.db);
    end else begin
      gains_next = goal;
    end
  end

  // advance loop state as the beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_position <= '0;
      ramp_started  <= 1'b0;
      tick_counter  <= '0;
      gains         <= '0;
      gains_loaded  <= 1'b0;
    end else if (load[1]) begin
      if (is_tick) begin
        tick_counter <= do_update ? '0 : tick_inc;
        if (do_update) begin
          ramp_position <= ramp_next;
          ramp_started  <= 1'b1;
        end
      end else begin
        gains        <= gains_next;
        gains_loaded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_upd   <= do_update;
      s1_err   <= err_db;
      s1_speed <= s0_speed;
      s1_k     <= gains.k;
      s1_b     <= gains.b;
      s1_lim   <= gains.lim;
      s1_pos   <= do_update ? ramp_next : ramp_position;
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_upd <= s1_upd;
      s2_pk  <= PROD_W'($signed({1'b0, s1_k})) * PROD_W'(s1_err);
      s2_pb  <= PROD_W'($signed({1'b0, s1_b})) * PROD_W'(s1_speed);
      s2_lim <= s1_lim;
      s2_pos <= s1_pos;
    end
  end

  always_comb begin
    imp_sum    = SUM_W'(s2_pk) - SUM_W'(s2_pb);
    imp_biased = imp_sum + SUM_W'(imp_sum[SUM_W-1] ? (1 << 23) - 1 : (1 << 23));
    imp_round  = imp_biased[SUM_W-1:24];
    lim_ext    = $signed({(RND_W - GAIN_W)'(0), s2_lim});
    if (imp_round > lim_ext) begin
      imp_clamp = lim_ext;
    end else if (imp_round < -lim_ext) begin
      imp_clamp = -lim_ext;
    end else begin
      imp_clamp = imp_round;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s3_upd <= s2_upd;
      s3_iq  <= imp_clamp[IQ_W-1:0];
      s3_pos <= s2_pos;
    end
    if (load[4]) begin
      s4_upd <= s3_upd;
      s4_iq  <= s3_iq;
      s4_pos <= s3_pos;
    end
    if (load[5]) begin
      s5_upd <= s4_upd;
      s5_iq  <= s4_iq;
      s5_pos <= s4_pos;
    end
  end

  ipl_gravity #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_gravity (
    .clk        (clk),
    .stage_load (load[5:1]),
    .meas       (s0_meas),
    .offset     (gravity_offset),
    .gain       (gravity_gain),
    .grav       (grav)
  );

  assign total = TOT_W'(s5_iq) + TOT_W'(grav);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_iq <= '0;
    end else if (load[LAST] && s5_upd) begin
      out_iq <= POS_W'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (load[LAST]) begin
      out_pos <= s5_pos;
      out_upd <= s5_upd;
    end
  end

  assign m_tvalid = vld[LAST];
  assign m_tdata  = {out_pos, out_iq};
  assign m_tuser  = out_upd;

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

  a_gains_zero_until_loaded: assert property (@(posedge clk) disable iff (rst)
    !gains_loaded |-> (gains == '0))
    else $error("gains changed before any set-mode beat");

  a_gains_in_range: assert property (@(posedge clk) disable iff (rst)
    gains_loaded |-> (gains.k >= SOFT_SET.k && gains.k <= HARD_SET.k &&
                      gains.db >= HARD_SET.db && gains.db <= SOFT_SET.db))
    else $error("blended gains left the span of the gain sets");

  a_ramp_idle_at_zero: assert property (@(posedge clk) disable iff (rst)
    !ramp_started |-> (ramp_position == '0))
    else $error("ramp moved before its first update");
`endif

endmodule

// ===== tb/impedance_loop_check.sv =====
`timescale 1ns / 100ps

module impedance_loop_check #(
  parameter int SINE_TABLE_DEPTH = ipl_pkg::SINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [103:0]             s_tdata,
  input  logic [0:0]               s_tuser,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [63:0]              m_tdata,
  input  logic [0:0]               m_tuser,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [ipl_pkg::CFG_W-1:0] cfg_data,
  output int                       fail_count,
  output int                       expected_left,
  output int                       update_count
);

  localparam longint FULL_TURN = longint'(ipl_pkg::TURN_DIV) << ipl_pkg::TURN_SHIFT;

  typedef struct {
    logic signed [31:0] iq;
    logic signed [31:0] pos;
    logic               upd;
  } loop_out_t;

  loop_out_t loop_out_q[$];

  longint      ramp_step_r;
  longint      grav_gain_r;
  longint      grav_offset_r;
  logic [15:0] loop_div_r;

  longint      ramp_pos;
  logic        ramp_started;
  logic [15:0] tick_count;
  longint      k_gain;
  longint      b_gain;
  longint      cur_limit;
  longint      dead_band;
  logic        gains_loaded;
  longint      held_iq;

  function automatic longint round_half(input longint v, input int s);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint blend(input longint cur, input longint goal);
    return cur + round_half((goal - cur) * ipl_pkg::BLEND_ALPHA, 16);
  endfunction

  function automatic loop_out_t run_position_loop(input ipl_pkg::opcode_t op,
                                                  input ipl_pkg::mode_t mode,
                                                  input logic signed [31:0] tgt,
                                                  input logic signed [31:0] meas,
                                                  input logic signed [31:0] spd);
    loop_out_t o;
    longint gk, gb, gl, gd, e, err, iq, ang, grav, total, entry;
    longint unsigned idx, p, quad, r, x, x2, term, acc;
    logic neg;
    o.upd = 1'b0;
    if (op == ipl_pkg::OP_SET_MODE) begin
      case (mode)
        ipl_pkg::MODE_SOFT: begin
          gk = 838861;  gb = 50332;  gl = 131072; gd = 9830;
        end
        ipl_pkg::MODE_HARD: begin
          gk = 5033165; gb = 251658; gl = 262144; gd = 5243;
        end
        default: begin
          gk = 2013266; gb = 100663; gl = 196608; gd = 6554;
        end
      endcase
      if (!gains_loaded) begin
        k_gain = gk;
        b_gain = gb;
        cur_limit = gl;
        dead_band = gd;
        gains_loaded = 1'b1;
      end else begin
        k_gain = blend(k_gain, gk);
        b_gain = blend(b_gain, gb);
        cur_limit = blend(cur_limit, gl);
        dead_band = blend(dead_band, gd);
      end
    end else begin
      tick_count = tick_count + 16'd1;
      if (tick_count >= loop_div_r) begin
        tick_count = '0;
        o.upd = 1'b1;
        if (!ramp_started) begin
          ramp_pos = meas;
          ramp_started = 1'b1;
        end
        e = longint'(tgt) - ramp_pos;
        if (e <= ipl_pkg::SNAP_WINDOW && e >= -ipl_pkg::SNAP_WINDOW)
          ramp_pos = tgt;
        else if (e > 0)
          ramp_pos += (e > ramp_step_r) ? ramp_step_r : e;
        else
          ramp_pos += (e < -ramp_step_r) ? -ramp_step_r : e;

        err = ramp_pos - longint'(meas);
        if (err < dead_band && -err < dead_band)
          err = 0;
        iq = round_half(k_gain * err - b_gain * longint'(spd), 24);
        if (iq > cur_limit)
          iq = cur_limit;
        if (iq < -cur_limit)
          iq = -cur_limit;

        ang = (longint'(meas) - grav_offset_r) % FULL_TURN;
        if (ang < 0)
          ang += FULL_TURN;
        idx = (longint'(ang) * SINE_TABLE_DEPTH) / FULL_TURN;

        // sine by quadrant folding and a Q30 series
        p = (idx << 32) / SINE_TABLE_DEPTH;
        quad = (p >> 30) & 64'd3;
        r = p & 64'h3FFF_FFFF;
        if (quad[0])
          r = 64'h4000_0000 - r;
        x = (r * ipl_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        neg = 1'b1;
        for (int n = 1; n <= 6; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          acc = neg ? acc - term : acc + term;
          neg = !neg;
        end
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767)
          acc = 64'd32767;
        entry = (quad >= 2) ? -longint'(acc) : longint'(acc);
        grav = round_half(grav_gain_r * entry, 23);

        total = iq + grav;
        if (total > 64'sd2147483647)
          total = 64'sd2147483647;
        if (total < -64'sd2147483648)
          total = -64'sd2147483648;
        held_iq = total;
      end
    end
    o.iq = held_iq[31:0];
    o.pos = ramp_pos[31:0];
    return o;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    loop_out_t want;
    loop_out_t got;
    if (rst) begin
      ramp_step_r = 65536;
      grav_gain_r = 6375342;
      grav_offset_r = 0;
      loop_div_r = 16'd10;
      ramp_pos = 0;
      ramp_started = 1'b0;
      tick_count = '0;
      k_gain = 0;
      b_gain = 0;
      cur_limit = 0;
      dead_band = 0;
      gains_loaded = 1'b0;
      held_iq = 0;
      loop_out_q.delete();
      expected_left <= 0;
    end else begin
      if (cfg_write) begin
        case (ipl_pkg::cfg_reg_t'(cfg_index))
          ipl_pkg::CFG_RAMP_STEP:      ramp_step_r = longint'(cfg_data[30:0]);
          ipl_pkg::CFG_GRAVITY_GAIN:   grav_gain_r = longint'(cfg_data[30:0]);
          ipl_pkg::CFG_GRAVITY_OFFSET: grav_offset_r = longint'($signed(cfg_data[25:0]));
          ipl_pkg::CFG_LOOP_DIVIDER:   loop_div_r = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = run_position_loop(ipl_pkg::opcode_t'(s_tuser[0]),
                                 ipl_pkg::mode_t'(s_tdata[1:0]),
                                 s_tdata[33:2], s_tdata[65:34], s_tdata[97:66]);
        if (want.upd)
          update_count++;
        loop_out_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.iq = m_tdata[31:0];
        got.pos = m_tdata[63:32];
        got.upd = m_tuser[0];
        if (loop_out_q.size() == 0) begin
          report("output beat with no result pending, iq_command", got.iq, 0);
        end else begin
          want = loop_out_q.pop_front();
          if (got.iq !== want.iq)
            report("iq_command", got.iq, want.iq);
          if (got.pos !== want.pos)
            report("position_command", got.pos, want.pos);
          if (got.upd !== want.upd)
            report("updated", got.upd, want.upd);
        end
      end
      expected_left <= loop_out_q.size();
    end
  end

endmodule

// ===== tb/impedance_position_loop_core_tb.sv =====
`timescale 1ns / 100ps

module impedance_position_loop_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TURN = ipl_pkg::TURN_DIV << ipl_pkg::TURN_SHIFT;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_PERIODIC,
    RX_COIN
  } rx_style_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [103:0]   s_tdata = '0;   // impedance_mode, setpoint, measured_position,
                                  // measured_speed, zero pad
  logic [0:0]     s_tuser = '0;   // opcode
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [63:0]    m_tdata;        // iq_command, position_command
  logic [0:0]     m_tuser;        // updated
  logic           cfg_write = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [ipl_pkg::CFG_W-1:0] cfg_data = '0;

  int fail_count;
  int expected_left;
  int update_count;

  int cycles = 0;
  int tick_beats = 0;
  int mode_beats = 0;
  int settings = 1;
  int burst_left = 0;
  int track_pos = 0;
  int aim_pos = 0;

  rx_style_t  rx_style = RX_OPEN;
  int         rx_left = 0;
  logic [2:0] rx_phase = '0;

  impedance_position_loop_core #(
    .SINE_TABLE_DEPTH(ipl_pkg::SINE_DEPTH_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  impedance_loop_check #(
    .SINE_TABLE_DEPTH(ipl_pkg::SINE_DEPTH_DEF)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .expected_left(expected_left),
    .update_count (update_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_OPEN:     m_tready <= 1'b1;
      RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: m_tready <= (rx_phase != 3'd0);
      default:     m_tready <= ($urandom_range(0, 1) == 1);
    endcase
    rx_phase <= rx_phase + 3'd1;
  end

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_beat(input ipl_pkg::opcode_t op, input logic [1:0] mode,
                           input logic [31:0] tgt, input logic [31:0] meas,
                           input logic [31:0] spd);
    pace();
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, spd, meas, tgt, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == ipl_pkg::OP_TICK)
      tick_beats++;
    else
      mode_beats++;
  endtask

  // hold off until every pending result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [30:0] step, input logic [30:0] gain, input int off,
                          input logic [15:0] div);
    cfg_write <= 1'b1;
    cfg_index <= ipl_pkg::CFG_RAMP_STEP;
    cfg_data <= step;
    @(posedge clk);
    cfg_index <= ipl_pkg::CFG_GRAVITY_GAIN;
    cfg_data <= gain;
    @(posedge clk);
    cfg_index <= ipl_pkg::CFG_GRAVITY_OFFSET;
    cfg_data <= ipl_pkg::CFG_W'(off);
    @(posedge clk);
    cfg_index <= ipl_pkg::CFG_LOOP_DIVIDER;
    cfg_data <= ipl_pkg::CFG_W'(div);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  task automatic random_beat();
    int roll;
    int tgt;
    int meas;
    int spd;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      send_beat(ipl_pkg::OP_SET_MODE, 2'($urandom_range(0, 3)), $urandom, $urandom,
                $urandom);
    end else if (roll < 28) begin
      send_beat(ipl_pkg::OP_TICK, 2'($urandom), $urandom, $urandom, $urandom);
    end else begin
      // plausible joint motion: measured position trails a slowly moving aim point
      if ($urandom_range(0, 15) == 0)
        aim_pos = track_pos + int'($urandom_range(0, 4000000)) - 2000000;
      if ($urandom_range(0, 60) == 0) begin
        track_pos = int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        aim_pos = track_pos;
      end
      track_pos = track_pos + (aim_pos - track_pos) / 8 + int'($urandom_range(0, 2000)) - 1000;
      tgt = aim_pos;
      meas = track_pos + int'($urandom_range(0, 40000)) - 20000;
      spd = int'($urandom_range(0, 2000000)) - 1000000;
      send_beat(ipl_pkg::OP_TICK, 2'($urandom), tgt, meas, spd);
    end
  endtask

  initial begin
    int n_items;
    int pause_at;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default divider: these ticks only advance the counter
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_SOFT, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0000_0000);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_HARD, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF);
    drain();
    set_regs(31'd65536, 31'd6375342, 0, 16'd1);

    // no gains yet: gravity only; ramp starts at the measurement, then snap edges
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'd0, 32'd0, 32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'(ipl_pkg::SNAP_WINDOW), 32'd0,
              32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'(-1), 32'd0, 32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'(-200001), 32'd0, 32'd0);

    // first set-mode loads soft gains; probe the deadband edges
    send_beat(ipl_pkg::OP_SET_MODE, ipl_pkg::MODE_SOFT, 32'd0, 32'd0, 32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_SOFT, 32'(-65537), 32'(-65537 - 9829), 32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_SOFT, 32'(-65537), 32'(-65537 - 9830), 32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_SOFT, 32'(-65537), 32'(-65537 + 9830),
              32'h7FFF_FFFF);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_SOFT, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_SOFT, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000);

    // later set-modes blend, including the out-of-range mode
    send_beat(ipl_pkg::OP_SET_MODE, ipl_pkg::MODE_HARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_beat(ipl_pkg::OP_SET_MODE, 2'd3, 32'd0, 32'd0, 32'd0);
    send_beat(ipl_pkg::OP_SET_MODE, ipl_pkg::MODE_NORMAL, 32'd0, 32'd0, 32'd0);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'd1000000, 32'd990000,
              32'(-500000));
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'd1000000, 32'd1050000, 32'd500000);
    send_beat(ipl_pkg::OP_TICK, ipl_pkg::MODE_NORMAL, 32'd1000000, 32'(-3000000), 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_regs(31'd0, 31'd0, -TURN, 16'd1);
        1: set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, TURN, 16'hFFFF);
        2: set_regs($urandom_range(1000, 200000), $urandom_range(0, 20000000),
                    int'($urandom_range(0, 2 * TURN)) - TURN, 16'd0);
        default: set_regs($urandom_range(0, 300000), $urandom_range(0, 20000000),
                          int'($urandom_range(0, 2 * TURN)) - TURN,
                          16'($urandom_range(1, 6)));
      endcase
      n_items = (ph == 1) ? 40 : 210;
      pause_at = $urandom_range(10, n_items - 10);
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at)
          drain();
        random_beat();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d control ticks and %0d set-mode beats across %0d register settings",
             tick_beats, mode_beats, settings);
    $display("%0d ticks ran a position loop update", update_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
